[src/b2b_pkg.sv]
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared types and constants of the BLAKE2b compression core.
// ----------------------------------------------------------------------------
`default_nettype none
package b2b_pkg;

   localparam int ROUNDS = 12;
   localparam int ROUND_W = $clog2(ROUNDS + 1);
   localparam int SIGMA_ROWS = 10;

   typedef enum logic [1:0] {
      OP_CHAIN    = 2'd0,
      OP_MESSAGE  = 2'd1,
      OP_COMPRESS = 2'd2,
      OP_UNUSED   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic       chain_we;
      logic [2:0] chain_waddr;
      logic [2:0] chain_raddr;
      logic       msg_we;
      logic [3:0] msg_waddr;
      logic [3:0] msg_raddr;
   } mem_ctrl_type;

   localparam logic [63:0] IV [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [3:0] SIGMA [SIGMA_ROWS][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

endpackage
`default_nettype wire

[src/b2b_store.sv]
// ----------------------------------------------------------------------------
// b2b_store
// Chain word and message word memories, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
`default_nettype none
module b2b_store (
   input  wire logic                  clock,
   input  wire b2b_pkg::mem_ctrl_type ctrl,
   input  wire logic [63:0]           chain_wdata,
   input  wire logic [63:0]           msg_wdata,
   output logic [63:0]                chain_rdata,
   output logic [63:0]                msg_rdata
);
   import b2b_pkg::*;

   logic [63:0] chain_mem [8];
   logic [63:0] msg_mem [16];
   logic [63:0] chain_rdata_ff;
   logic [63:0] msg_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctrl.chain_we) begin
         chain_mem[ctrl.chain_waddr] <= chain_wdata;
      end
      chain_rdata_ff <= chain_mem[ctrl.chain_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.msg_we) begin
         msg_mem[ctrl.msg_waddr] <= msg_wdata;
      end
      msg_rdata_ff <= msg_mem[ctrl.msg_raddr];
   end

   assign chain_rdata = chain_rdata_ff;
   assign msg_rdata   = msg_rdata_ff;

endmodule
`default_nettype wire

[src/b2b_mix.sv]
// ----------------------------------------------------------------------------
// b2b_mix
// One half of the G mixing function on four working words.
// ----------------------------------------------------------------------------
`default_nettype none
module b2b_mix (
   input  wire logic        second_half,
   input  wire logic [63:0] a_word,
   input  wire logic [63:0] b_word,
   input  wire logic [63:0] c_word,
   input  wire logic [63:0] d_word,
   input  wire logic [63:0] msg_word,
   output logic [63:0]      a_out,
   output logic [63:0]      b_out,
   output logic [63:0]      c_out,
   output logic [63:0]      d_out
);
   import b2b_pkg::*;

   logic [63:0] a_sum;
   logic [63:0] d_x;
   logic [63:0] c_sum;
   logic [63:0] b_x;

   always_comb begin
      a_sum = a_word + b_word + msg_word;
      d_x   = d_word ^ a_sum;
      if (second_half) begin
         d_out = {d_x[15:0], d_x[63:16]};
      end else begin
         d_out = {d_x[31:0], d_x[63:32]};
      end
      c_sum = c_word + d_out;
      b_x   = b_word ^ c_sum;
      if (second_half) begin
         b_out = {b_x[62:0], b_x[63]};
      end else begin
         b_out = {b_x[23:0], b_x[63:24]};
      end
      a_out = a_sum;
      c_out = c_sum;
   end

endmodule
`default_nettype wire

[src/blake2b_compression_core.sv]
// ----------------------------------------------------------------------------
// blake2b_compression_core
// BLAKE2b compression: chain and message words loaded by write commands,
// twelve rounds of G run on a compress command, eight chain words returned.
// ----------------------------------------------------------------------------
// A write command leaves busy low. A compress command holds busy while it
// reads the chain words into the working vector, runs one half-G per cycle
// on the shared mix unit (sixteen per round, one message word read per
// cycle), and reads, updates and writes back the chain words. The eight
// results come on consecutive cycles, one per strobe, and cannot be stalled:
// the last one appears in the same cycle that busy falls.
// ----------------------------------------------------------------------------
`default_nettype none
module blake2b_compression_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [3:0]  req_word_index,
   input  wire logic [63:0] req_data_word,
   input  wire logic [63:0] req_counter_low,
   input  wire logic [63:0] req_counter_high,
   input  wire logic [63:0] req_final_block_word,
   input  wire logic [63:0] req_final_node_word,
   output logic             rsp_valid,
   output logic [63:0]      rsp_hash_word,
   output logic [2:0]       rsp_hash_index,
   output logic             rsp_last_word
);
   import b2b_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MIX,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [3:0]           count_ff, count_in;
   logic [3:0]           step_ff, step_in;
   logic [3:0]           row_ff, row_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic [63:0]          v_ff [16];
   logic [63:0]          v_in [16];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_word_ff, rsp_word_in;
   logic [2:0]           rsp_index_ff, rsp_index_in;
   logic                 rsp_last_ff, rsp_last_in;

   mem_ctrl_type         ctrl;
   logic [63:0]          chain_wdata;
   logic [63:0]          chain_rdata;
   logic [63:0]          msg_rdata;
   logic                 accept;
   logic                 diag;
   logic [63:0]          a_out, b_out, c_out, d_out;
   logic [63:0]          new_word;
   logic [3:0]           next_step;
   logic [3:0]           next_row;

   b2b_store u_store (
      .clock       (clock),
      .ctrl        (ctrl),
      .chain_wdata (chain_wdata),
      .msg_wdata   (req_data_word),
      .chain_rdata (chain_rdata),
      .msg_rdata   (msg_rdata)
   );

   assign diag = step_ff[3];

   b2b_mix u_mix (
      .second_half (step_ff[0]),
      .a_word      (v_ff[0]),
      .b_word      (diag ? v_ff[5] : v_ff[4]),
      .c_word      (diag ? v_ff[10] : v_ff[8]),
      .d_word      (diag ? v_ff[15] : v_ff[12]),
      .msg_word    (msg_rdata),
      .a_out       (a_out),
      .b_out       (b_out),
      .c_out       (c_out),
      .d_out       (d_out)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign new_word  = chain_rdata ^ v_ff[0] ^ v_ff[8];
   assign next_step = step_ff + 4'd1;
   assign next_row  = (step_ff != 4'd15) ? row_ff :
                      ((row_ff == 4'(SIGMA_ROWS - 1)) ? 4'd0 : row_ff + 4'd1);

   always_comb begin
      logic [63:0] t [16];
      ctrl        = '0;
      chain_wdata = req_data_word;
      state_in    = state_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      row_in      = row_ff;
      round_in    = round_ff;
      v_in        = v_ff;
      t           = v_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            ctrl.chain_waddr = req_word_index[2:0];
            ctrl.msg_waddr   = req_word_index;
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_CHAIN: ctrl.chain_we = !req_word_index[3];
                  OP_MESSAGE: ctrl.msg_we = 1'b1;
                  OP_COMPRESS: begin
                     for (int i = 0; i < 8; i++) begin
                        v_in[8 + i] = IV[i];
                     end
                     v_in[12] = IV[4] ^ req_counter_low;
                     v_in[13] = IV[5] ^ req_counter_high;
                     v_in[14] = IV[6] ^ req_final_block_word;
                     v_in[15] = IV[7] ^ req_final_node_word;
                     count_in = 4'd0;
                     state_in = ST_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            ctrl.chain_raddr = count_ff[2:0];
            ctrl.msg_raddr   = SIGMA[0][0];
            if (count_ff != 4'd0) begin
               for (int i = 0; i < 7; i++) begin
                  v_in[i] = v_ff[i + 1];
               end
               v_in[7] = chain_rdata;
            end
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd8) begin
               step_in  = 4'd0;
               row_in   = 4'd0;
               round_in = '0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            ctrl.msg_raddr = SIGMA[next_row][next_step];
            t[0] = a_out;
            if (diag) begin
               t[5] = b_out; t[10] = c_out; t[15] = d_out;
            end else begin
               t[4] = b_out; t[8] = c_out; t[12] = d_out;
            end
            for (int i = 0; i < 16; i++) begin
               if (step_ff[0]) begin
                  v_in[i] = t[(i & 12) | ((i + 1) & 3)];
               end else begin
                  v_in[i] = t[i];
               end
            end
            step_in = next_step;
            row_in  = next_row;
            if (step_ff == 4'd15) begin
               round_in = round_ff + ROUND_W'(1);
               if (round_ff == ROUND_W'(ROUNDS - 1)) begin
                  count_in = 4'd0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            ctrl.chain_raddr = count_ff[2:0];
            ctrl.chain_waddr = 3'(count_ff - 4'd1);
            chain_wdata      = new_word;
            if (count_ff != 4'd0) begin
               ctrl.chain_we = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_word_in   = new_word;
               rsp_index_in  = 3'(count_ff - 4'd1);
               rsp_last_in   = (count_ff == 4'd8);
               for (int i = 0; i < 7; i++) begin
                  v_in[i]     = v_ff[i + 1];
                  v_in[8 + i] = v_ff[9 + i];
               end
            end
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd8) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         row_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         row_ff       <= row_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_word  = rsp_word_ff;
   assign rsp_hash_index = rsp_index_ff;
   assign rsp_last_word  = rsp_last_ff;

endmodule
`default_nettype wire

[src/b2b_checker.sv]
// ----------------------------------------------------------------------------
// b2b_checker
// Port-level checks on the result burst of the compression core.
// ----------------------------------------------------------------------------
`default_nettype none
module b2b_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_hash_index,
   input wire logic       rsp_last_word
);
   import b2b_pkg::*;

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |=> rsp_valid)
      else $error("result burst broken");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |=> rsp_hash_index == $past(rsp_hash_index) + 3'd1)
      else $error("result index out of order");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_hash_index == 3'd7)))
      else $error("last word flag wrong");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |-> busy)
      else $error("result transfer while idle");

endmodule

bind blake2b_compression_core b2b_checker u_b2b_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hash_index (rsp_hash_index),
   .rsp_last_word  (rsp_last_word)
);
`default_nettype wire

[tb/sv/blake2b_compression_core_tb.sv]
// ----------------------------------------------------------------------------
// blake2b_compression_core_tb
// Self-checking bench for the BLAKE2b compression core: a directed table of
// loads and compress commands, then random blocks, each compress predicted
// by a behavioral G round model and checked word by word on the result port.
// ----------------------------------------------------------------------------
`default_nettype none
module blake2b_compression_core_tb;
   import b2b_pkg::*;

   typedef struct {
      opcode_type  op;
      logic [3:0]  idx;
      logic [63:0] data;
      logic [63:0] cnt_lo;
      logic [63:0] cnt_hi;
      logic [63:0] fin_blk;
      logic [63:0] fin_node;
   } cmd_type;

   typedef struct {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } hash_out_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [3:0]  req_word_index;
   logic [63:0] req_data_word;
   logic [63:0] req_counter_low;
   logic [63:0] req_counter_high;
   logic [63:0] req_final_block_word;
   logic [63:0] req_final_node_word;
   logic        rsp_valid;
   logic [63:0] rsp_hash_word;
   logic [2:0]  rsp_hash_index;
   logic        rsp_last_word;

   logic [63:0]  chain_model [8];
   logic [63:0]  msg_model [16];
   hash_out_type hash_queue [$];
   cmd_type      table_cmds [$];
   int           error_count = 0;
   int           idle_cycles = 0;

   blake2b_compression_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_word_index(req_word_index),
      .req_data_word(req_data_word), .req_counter_low(req_counter_low),
      .req_counter_high(req_counter_high),
      .req_final_block_word(req_final_block_word),
      .req_final_node_word(req_final_node_word),
      .rsp_valid(rsp_valid), .rsp_hash_word(rsp_hash_word),
      .rsp_hash_index(rsp_hash_index), .rsp_last_word(rsp_last_word)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rotr(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic void g_mix(ref logic [63:0] v [16], input int a, int b, int c,
                                 int d, logic [63:0] x, logic [63:0] y);
      v[a] = v[a] + v[b] + x;
      v[d] = rotr(v[d] ^ v[a], 32);
      v[c] = v[c] + v[d];
      v[b] = rotr(v[b] ^ v[c], 24);
      v[a] = v[a] + v[b] + y;
      v[d] = rotr(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d];
      v[b] = rotr(v[b] ^ v[c], 63);
   endfunction

   function automatic void predict_hash(cmd_type c);
      logic [63:0]  v [16];
      logic [3:0]   s [16];
      hash_out_type h;
      case (c.op)
         OP_CHAIN: begin
            if (c.idx < 8) chain_model[c.idx[2:0]] = c.data;
         end
         OP_MESSAGE: msg_model[c.idx] = c.data;
         OP_COMPRESS: begin
            for (int i = 0; i < 8; i++) begin
               v[i] = chain_model[i];
               v[i + 8] = IV[i];
            end
            v[12] ^= c.cnt_lo;
            v[13] ^= c.cnt_hi;
            v[14] ^= c.fin_blk;
            v[15] ^= c.fin_node;
            for (int r = 0; r < ROUNDS; r++) begin
               s = SIGMA[r % SIGMA_ROWS];
               g_mix(v, 0, 4, 8, 12, msg_model[s[0]], msg_model[s[1]]);
               g_mix(v, 1, 5, 9, 13, msg_model[s[2]], msg_model[s[3]]);
               g_mix(v, 2, 6, 10, 14, msg_model[s[4]], msg_model[s[5]]);
               g_mix(v, 3, 7, 11, 15, msg_model[s[6]], msg_model[s[7]]);
               g_mix(v, 0, 5, 10, 15, msg_model[s[8]], msg_model[s[9]]);
               g_mix(v, 1, 6, 11, 12, msg_model[s[10]], msg_model[s[11]]);
               g_mix(v, 2, 7, 8, 13, msg_model[s[12]], msg_model[s[13]]);
               g_mix(v, 3, 4, 9, 14, msg_model[s[14]], msg_model[s[15]]);
            end
            for (int i = 0; i < 8; i++) begin
               chain_model[i] ^= v[i] ^ v[i + 8];
               h.word = chain_model[i];
               h.index = 3'(i);
               h.last = (i == 7);
               hash_queue.push_back(h);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] edge64();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   function automatic cmd_type make_cmd(opcode_type op, logic [3:0] idx, logic [63:0] d);
      cmd_type c;
      c.op = op;
      c.idx = idx;
      c.data = d;
      c.cnt_lo = rand64();
      c.cnt_hi = rand64();
      c.fin_blk = rand64();
      c.fin_node = rand64();
      return c;
   endfunction

   task automatic issue_cmd(cmd_type c);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= c.op;
      req_word_index <= c.idx;
      req_data_word <= c.data;
      req_counter_low <= c.cnt_lo;
      req_counter_high <= c.cnt_hi;
      req_final_block_word <= c.fin_blk;
      req_final_node_word <= c.fin_node;
      do @(posedge clock); while (busy);
      predict_hash(c);
   endtask

   task automatic drop_start();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic random_block();
      for (int i = 0; i < 8; i++) issue_cmd(make_cmd(OP_CHAIN, 4'(i), edge64()));
      for (int i = 0; i < 16; i++) issue_cmd(make_cmd(OP_MESSAGE, 4'(i), edge64()));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (hash_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_hash_word, '0);
            end else begin
               hash_out_type h;
               h = hash_queue.pop_front();
               if (rsp_hash_word !== h.word) report_mismatch("hash_word", rsp_hash_word, h.word);
               if (rsp_hash_index !== h.index)
                  report_mismatch("hash_index", 64'(rsp_hash_index), 64'(h.index));
               if (rsp_last_word !== h.last)
                  report_mismatch("last_word", 64'(rsp_last_word), 64'(h.last));
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      cmd_type c;
      int      n;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_CHAIN;
      req_word_index = '0;
      req_data_word = '0;
      req_counter_low = '0;
      req_counter_high = '0;
      req_final_block_word = '0;
      req_final_node_word = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: all-zero block, all-ones block, ignored writes, unused opcode
      for (int i = 0; i < 8; i++) table_cmds.push_back('{OP_CHAIN, 4'(i), '0, '0, '0, '0, '0});
      for (int i = 0; i < 16; i++) table_cmds.push_back('{OP_MESSAGE, 4'(i), '1, '0, '0, '0, '0});
      table_cmds.push_back('{OP_COMPRESS, '0, '0, '0, '0, '0, '0});
      table_cmds.push_back('{OP_CHAIN, 4'd8, '1, '0, '0, '0, '0});
      table_cmds.push_back('{OP_CHAIN, 4'd15, '1, '0, '0, '0, '0});
      table_cmds.push_back('{OP_UNUSED, 4'd15, '1, '1, '1, '1, '1});
      table_cmds.push_back('{OP_COMPRESS, 4'd15, '1, '1, '1, '1, '1});
      table_cmds.push_back('{OP_COMPRESS, '0, '0, '1, '0, '1, '0});
      foreach (table_cmds[i]) issue_cmd(table_cmds[i]);

      random_block();
      n = 0;
      while (n < 100) begin
         case ($urandom_range(0, 9))
            0, 1, 2: c = make_cmd(OP_MESSAGE, 4'($urandom_range(0, 15)), edge64());
            3, 4: c = make_cmd(OP_CHAIN, 4'($urandom_range(0, 15)), edge64());
            5: c = make_cmd(OP_UNUSED, 4'($urandom_range(0, 15)), rand64());
            default: begin
               c = make_cmd(OP_COMPRESS, 4'($urandom_range(0, 15)), rand64());
               c.cnt_lo = edge64();
               c.cnt_hi = edge64();
               c.fin_blk = $urandom_range(0, 1) ? '1 : '0;
               c.fin_node = $urandom_range(0, 1) ? '1 : edge64();
            end
         endcase
         issue_cmd(c);
         n++;
         if (n == 70) begin
            drop_start();
            wait (hash_queue.size() == 0);
            repeat (30) @(negedge clock);
            random_block();
         end
      end

      drop_start();
      wait (hash_queue.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
